// ----- rtl/bmn_pkg.sv -----
package bmn_pkg;

  // input and output scaling
  localparam int FRAC_BITS     = 32;
  localparam int OUT_FRAC_BITS = 12;
  localparam int LOG_STEPS     = 28;
  localparam int OUT_SHIFT     = 58 - OUT_FRAC_BITS;

  localparam logic [31:0] FRAC_MASK    = 32'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [31:0] U1_FLOOR_RAW = 32'(429 >> (32 - FRAC_BITS));
  localparam logic [31:0] U1_FLOOR     = (U1_FLOOR_RAW == 32'd0) ? 32'd1 : U1_FLOOR_RAW;

  // fixed-point constants
  localparam logic [30:0] Q30_ONE     = 31'd1 << 30;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [28:0] TWO_LN2_Q28 = 29'd372130560;

  // Horner divisors and their reciprocals over 2^32, index = step
  localparam logic [3:0][6:0] COS_DIV = {7'd2, 7'd12, 7'd30, 7'd56};
  localparam logic [3:0][6:0] SIN_DIV = {7'd6, 7'd20, 7'd42, 7'd72};
  localparam logic [3:0][31:0] COS_RECIP = {
    32'((64'd1 << 32) / 2), 32'((64'd1 << 32) / 12),
    32'((64'd1 << 32) / 30), 32'((64'd1 << 32) / 56)};
  localparam logic [3:0][31:0] SIN_RECIP = {
    32'((64'd1 << 32) / 6), 32'((64'd1 << 32) / 20),
    32'((64'd1 << 32) / 42), 32'((64'd1 << 32) / 72)};

endpackage

// ----- rtl/bmn_log.sv -----
module bmn_log (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] u1,
  input  logic [31:0] u2,
  output logic        out_vld,
  output logic [33:0] r,
  output logic [31:0] u2_out
);
  import bmn_pkg::*;

  // squaring chain, level 0 holds the normalised mantissa
  logic              lvl_vld [LOG_STEPS+1];
  logic [31:0]       lvl_m   [LOG_STEPS+1];
  logic [5:0]        lvl_e   [LOG_STEPS+1];
  logic [LOG_STEPS-1:0] lvl_f [LOG_STEPS+1];
  logic [31:0]       lvl_u2  [LOG_STEPS+1];

  logic [31:0] u1m, u1f, m_n;
  logic [4:0]  p;

  // floor and normalise
  always_comb begin
    u1m = u1 & FRAC_MASK;
    u1f = (u1m < U1_FLOOR) ? U1_FLOOR : u1m;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (u1f[i]) p = 5'(i);
    end
    m_n = u1f << (5'd31 - p);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_vld[0] <= 1'b0;
    end else if (en) begin
      lvl_vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lvl_m[0]  <= m_n;
      lvl_e[0]  <= 6'(FRAC_BITS) - {1'b0, p};
      lvl_f[0]  <= '0;
      lvl_u2[0] <= u2;
    end
  end

  // one squaring per stage, one fraction bit out
  for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] s;
    always_comb begin
      sq = {32'd0, lvl_m[k-1]} * {32'd0, lvl_m[k-1]};
      s  = sq[63:31];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        lvl_vld[k] <= 1'b0;
      end else if (en) begin
        lvl_vld[k] <= lvl_vld[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lvl_m[k]  <= s[32] ? s[32:1] : s[31:0];
        lvl_f[k]  <= {lvl_f[k-1][LOG_STEPS-2:0], s[32]};
        lvl_e[k]  <= lvl_e[k-1];
        lvl_u2[k] <= lvl_u2[k-1];
      end
    end
  end

  // -log2, scale by 2 ln2, round
  logic        nl_vld, pr_vld, r_vld;
  logic [33:0] nl;
  logic [62:0] prod;
  logic [62:0] rsum;
  logic [31:0] nl_u2, pr_u2, r_u2;

  assign rsum = prod + (63'd1 << 27);

  always_ff @(posedge clk) begin
    if (rst) begin
      nl_vld <= 1'b0;
      pr_vld <= 1'b0;
      r_vld  <= 1'b0;
    end else if (en) begin
      nl_vld <= lvl_vld[LOG_STEPS];
      pr_vld <= nl_vld;
      r_vld  <= pr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nl    <= {lvl_e[LOG_STEPS], {LOG_STEPS{1'b0}}} - 34'(lvl_f[LOG_STEPS]);
      nl_u2 <= lvl_u2[LOG_STEPS];
      prod  <= {29'd0, nl} * {34'd0, TWO_LN2_Q28};
      pr_u2 <= nl_u2;
      r     <= rsum[61:28];
      r_u2  <= pr_u2;
    end
  end

  assign out_vld = r_vld;
  assign u2_out  = r_u2;

endmodule

// ----- rtl/bmn_sqrt.sv -----
module bmn_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  logic [33:0] r,
  input  logic [31:0] u2,
  output logic        out_vld,
  output logic [30:0] root,
  output logic [31:0] u2_out
);
  import bmn_pkg::*;

  // one result bit per stage, most significant first
  logic        st_vld  [31];
  logic [62:0] st_rem  [31];
  logic [30:0] st_root [31];
  logic [31:0] st_u2   [31];

  for (genvar i = 0; i < 31; i++) begin : g_bit
    localparam int K = 30 - i;
    logic        src_vld;
    logic [62:0] src_rem, trial;
    logic [30:0] src_root;
    logic [31:0] src_u2;

    if (i == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_rem  = {1'b0, r, 28'd0};
      assign src_root = '0;
      assign src_u2   = u2;
    end else begin : g_next
      assign src_vld  = st_vld[i-1];
      assign src_rem  = st_rem[i-1];
      assign src_root = st_root[i-1];
      assign src_u2   = st_u2[i-1];
    end

    // (root + 2^K)^2 - root^2
    assign trial = ({32'd0, src_root} << (K + 1)) + (63'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[i] <= 1'b0;
      end else if (en) begin
        st_vld[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_u2[i] <= src_u2;
        if (src_rem >= trial) begin
          st_rem[i]  <= src_rem - trial;
          st_root[i] <= src_root | (31'd1 << K);
        end else begin
          st_rem[i]  <= src_rem;
          st_root[i] <= src_root;
        end
      end
    end
  end

  assign out_vld = st_vld[30];
  assign root    = st_root[30];
  assign u2_out  = st_u2[30];

endmodule

// ----- rtl/bmn_cos.sv -----
module bmn_cos (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] u2,
  input  logic [30:0] root,
  output logic        out_vld,
  output logic [30:0] c,
  output logic        neg,
  output logic [30:0] root_out
);
  import bmn_pkg::*;

  localparam int NSTG = 16;

  typedef struct packed {
    logic [30:0] tt;
    logic [29:0] a;
    logic [29:0] a2;
    logic [30:0] v;
    logic [29:0] x;
    logic [29:0] q;
    logic        sin_br;
    logic        neg;
    logic [30:0] root;
  } cos_t;

  logic st_vld [NSTG];
  cos_t st     [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    cos_t nxt;

    if (s == 0) begin : g_quad
      // quadrant fold onto a quarter turn
      logic [31:0] ph;
      logic [1:0]  quad;
      always_comb begin
        ph   = (u2 & FRAC_MASK) << (32 - FRAC_BITS);
        quad = ph[31:30];
        nxt  = '0;
        nxt.root = root;
        nxt.neg  = (quad == 2'd1) || (quad == 2'd2);
        nxt.tt   = ((quad == 2'd0) || (quad == 2'd2)) ? {1'b0, ph[29:0]}
                                                     : Q30_ONE - {1'b0, ph[29:0]};
      end
    end else if (s == 1) begin : g_angle
      // angle in radians, sine branch above an eighth turn
      logic        br;
      logic [30:0] arg;
      logic [61:0] pa;
      always_comb begin
        nxt = st[s-1];
        br  = st[s-1].tt > (Q30_ONE >> 1);
        arg = br ? Q30_ONE - st[s-1].tt : st[s-1].tt;
        pa  = {31'd0, arg} * {31'd0, HALF_PI_Q30};
        nxt.sin_br = br;
        nxt.a      = pa[59:30];
      end
    end else if (s == 2) begin : g_sqr
      logic [59:0] pa2;
      always_comb begin
        nxt = st[s-1];
        pa2 = {30'd0, st[s-1].a} * {30'd0, st[s-1].a};
        nxt.a2 = pa2[59:30];
        nxt.v  = Q30_ONE;
      end
    end else if (s == NSTG - 1) begin : g_fin
      // sine branch multiplies by the angle
      logic [60:0] pv;
      always_comb begin
        nxt = st[s-1];
        pv  = {31'd0, st[s-1].a} * {30'd0, st[s-1].v};
        if (st[s-1].sin_br) nxt.v = pv[60:30];
      end
    end else begin : g_horner
      localparam int J  = (s - 3) / 3;
      localparam int PH = (s - 3) % 3;
      if (PH == 0) begin : g_mul
        logic [60:0] px;
        always_comb begin
          nxt = st[s-1];
          px  = {31'd0, st[s-1].a2} * {30'd0, st[s-1].v};
          nxt.x = px[59:30];
        end
      end else if (PH == 1) begin : g_recip
        // quotient estimate, may be one short
        logic [31:0] m;
        logic [61:0] pq;
        always_comb begin
          nxt = st[s-1];
          m   = st[s-1].sin_br ? SIN_RECIP[J] : COS_RECIP[J];
          pq  = {32'd0, st[s-1].x} * {30'd0, m};
          nxt.q = pq[61:32];
        end
      end else begin : g_fix
        // correct quotient, then 1 - quotient
        logic [6:0]  d;
        logic [36:0] qd, rm;
        logic [29:0] qc;
        always_comb begin
          nxt = st[s-1];
          d   = st[s-1].sin_br ? SIN_DIV[J] : COS_DIV[J];
          qd  = {7'd0, st[s-1].q} * {30'd0, d};
          rm  = {7'd0, st[s-1].x} - qd;
          qc  = (rm >= {30'd0, d}) ? st[s-1].q + 30'd1 : st[s-1].q;
          nxt.v = Q30_ONE - {1'b0, qc};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[s] <= 1'b0;
      end else if (en) begin
        st_vld[s] <= (s == 0) ? in_vld : st_vld[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s] <= nxt;
      end
    end
  end

  assign out_vld  = st_vld[NSTG-1];
  assign c        = st[NSTG-1].v;
  assign neg      = st[NSTG-1].neg;
  assign root_out = st[NSTG-1].root;

endmodule

// ----- rtl/bmn_out.sv -----
module bmn_out (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic [30:0] root,
  input  logic [30:0] c,
  input  logic        neg,
  output logic        en,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] sample
);
  import bmn_pkg::*;

  logic        pr_vld, pr_neg;
  logic [61:0] prod;
  logic [62:0] rsum, shifted;
  logic [14:0] mag;
  logic [15:0] res;
  logic        skid_vld;
  logic [15:0] skid;

  // pipeline moves unless the skid entry is occupied
  assign en = !skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_vld <= 1'b0;
    end else if (en) begin
      pr_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= {31'd0, root} * {31'd0, c};
      pr_neg <= neg;
    end
  end

  // round half away from zero, saturate, sign
  always_comb begin
    rsum    = {1'b0, prod} + (63'd1 << (OUT_SHIFT - 1));
    shifted = rsum >> OUT_SHIFT;
    mag     = (shifted > 63'd32767) ? 15'h7fff : shifted[14:0];
    res     = pr_neg ? 16'(-{1'b0, mag}) : {1'b0, mag};
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_vld) begin
        out_valid <= 1'b1;
        skid_vld  <= 1'b0;
      end else begin
        out_valid <= pr_vld;
      end
    end else if (pr_vld && !skid_vld) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      sample <= skid_vld ? skid : res;
    end else if (!skid_vld) begin
      skid <= res;
    end
  end

endmodule

// ----- rtl/box_muller_normal_sample_core.sv -----
// Data path: the log, square-root and cosine pipelines, then the product and output registers.
// Throughput: one sample per cycle while the output skid entry is empty; every stage then
// takes a new item each clock, and a full skid entry stalls all stages and drops in_ready.
// Stages: the 28 log squaring stages, 31 square-root bit stages and 16 cosine stages.
// Reset: synchronous rst clears all valid bits and the output skid entry.
module box_muller_normal_sample_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] u1_fraction,
  input  logic [31:0] u2_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] normal_sample
);
  import bmn_pkg::*;

  logic        en;
  logic        lg_vld, sq_vld, cs_vld, cs_neg;
  logic [33:0] lg_r;
  logic [31:0] lg_u2, sq_u2;
  logic [30:0] sq_root, cs_c, cs_root;
  logic [15:0] sample;

  assign in_ready = en;

  // -2 ln u1
  bmn_log u_log (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (in_valid),
    .u1     (u1_fraction),
    .u2     (u2_fraction),
    .out_vld(lg_vld),
    .r      (lg_r),
    .u2_out (lg_u2)
  );

  // square root
  bmn_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (lg_vld),
    .r      (lg_r),
    .u2     (lg_u2),
    .out_vld(sq_vld),
    .root   (sq_root),
    .u2_out (sq_u2)
  );

  // cos(2 pi u2)
  bmn_cos u_cos (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (sq_vld),
    .u2      (sq_u2),
    .root    (sq_root),
    .out_vld (cs_vld),
    .c       (cs_c),
    .neg     (cs_neg),
    .root_out(cs_root)
  );

  // product, rounding, output register
  bmn_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (cs_vld),
    .root     (cs_root),
    .c        (cs_c),
    .neg      (cs_neg),
    .en       (en),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample   (sample)
  );

  assign normal_sample = $signed(sample);

endmodule
